>>> rtl/rc6_block_cipher_top_defines.svh
// Assertion macros for the RC6 engine. Clock clk_i and reset rst_ni are implied.
`ifndef RC6_BLOCK_CIPHER_TOP_DEFINES_SVH
`define RC6_BLOCK_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RC6_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rc6: check failed");
`define RC6_ASSERT_SAME(lbl, ante, cons) `RC6_ASSERT(lbl, ante |-> cons)
`define RC6_ASSERT_NEXT(lbl, ante, cons) `RC6_ASSERT(lbl, ante |=> cons)
`else
`define RC6_ASSERT(lbl, prop)
`define RC6_ASSERT_SAME(lbl, ante, cons)
`define RC6_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/rc6_pkg.sv
package rc6_pkg;

  localparam int unsigned ROUNDS_DEF        = 20;
  localparam int unsigned MAX_KEY_BYTES_DEF = 32;

  localparam logic [31:0] MAGIC_P = 32'hB7E15163;
  localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned KEY_REG_N  = 4;
  localparam int unsigned KEY_BITS   = KEY_REG_N * CFG_DATA_W;
  localparam int unsigned KEY_LEN_W  = 6;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 6'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH   = 3'd4;

  // action codes
  localparam int unsigned ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_EXPAND  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENCRYPT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DECRYPT = 2'd2;

  typedef enum logic [1:0] {
    RD_PRE,
    RD_ROUND,
    RD_POST,
    RD_KEY
  } rc6_rd_sel_e;

  typedef struct packed {
    logic        dec;
    logic        key_load;
    logic        key_a;
    logic        key_b;
    logic        blk_load;
    logic        whiten_in;
    logic        round_mul;
    logic        round_add;
    logic        whiten_out;
    logic        out_load;
    logic        out_nokey;
    rc6_rd_sel_e rd_sel;
  } rc6_cmd_t;

  typedef struct packed {
    logic key_last;
    logic round_last;
  } rc6_stat_t;

  function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(logic [31:0] x, logic [4:0] n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

endpackage

>>> rtl/rc6_if.sv
interface rc6_in_if
  import rc6_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [31:0]      in_word_a;
  logic [31:0]      in_word_b;
  logic [31:0]      in_word_c;
  logic [31:0]      in_word_d;

  modport source (output valid, action, in_word_a, in_word_b, in_word_c, in_word_d,
                  input ready);
  modport sink   (input valid, action, in_word_a, in_word_b, in_word_c, in_word_d,
                  output ready);
endinterface

interface rc6_out_if
  import rc6_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [31:0] out_word_a;
  logic [31:0] out_word_b;
  logic [31:0] out_word_c;
  logic [31:0] out_word_d;
  logic        status;

  modport source (output valid, out_word_a, out_word_b, out_word_c, out_word_d, status,
                  input ready);
  modport sink   (input valid, out_word_a, out_word_b, out_word_c, out_word_d, status,
                  output ready);
endinterface

interface rc6_cfg_if
  import rc6_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/rc6_dp.sv
module rc6_dp
  import rc6_pkg::*;
#(
  parameter int unsigned ROUNDS        = ROUNDS_DEF,
  parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rc6_cmd_t              cmd_i,
  output rc6_stat_t             stat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [31:0]           in_word_a_i,
  input  logic [31:0]           in_word_b_i,
  input  logic [31:0]           in_word_c_i,
  input  logic [31:0]           in_word_d_i,
  output logic [31:0]           out_word_a_o,
  output logic [31:0]           out_word_b_o,
  output logic [31:0]           out_word_c_o,
  output logic [31:0]           out_word_d_o,
  output logic                  status_o
);

  localparam int unsigned RkCount = 2 * ROUNDS + 4;
  localparam int unsigned RkAw    = $clog2(RkCount);
  localparam int unsigned KwCount = (MAX_KEY_BYTES + 3) / 4;
  localparam int unsigned KwAw    = (KwCount > 1) ? $clog2(KwCount) : 1;
  localparam int unsigned CwW     = $clog2(KwCount + 1);
  localparam int unsigned RndW    = $clog2(ROUNDS + 1);
  localparam int unsigned StepMax = ((RkCount > KwCount) ? RkCount : KwCount) * 3;
  localparam int unsigned StepW   = $clog2(StepMax);

  localparam logic [RkAw-1:0] AddrLoA = RkAw'(0);
  localparam logic [RkAw-1:0] AddrLoB = RkAw'(1);
  localparam logic [RkAw-1:0] AddrHiA = RkAw'(2 * ROUNDS + 2);
  localparam logic [RkAw-1:0] AddrHiB = RkAw'(2 * ROUNDS + 3);

  // configuration registers
  logic [CFG_DATA_W-1:0] key_reg_q [KEY_REG_N];
  logic [KEY_LEN_W-1:0]  key_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < KEY_REG_N; r++) begin
        key_reg_q[r] <= '0;
      end
      key_len_q <= KEY_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEY_LOW:      key_reg_q[0] <= cfg_data_i;
        CFG_KEY_MID_LOW:  key_reg_q[1] <= cfg_data_i;
        CFG_KEY_MID_HIGH: key_reg_q[2] <= cfg_data_i;
        CFG_KEY_HIGH:     key_reg_q[3] <= cfg_data_i;
        CFG_KEY_LENGTH:   key_len_q    <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // key packing
  logic [KEY_BITS-1:0]  key_flat;
  logic [KEY_LEN_W-1:0] len_sat;
  logic [KEY_LEN_W:0]   len_p3;
  logic [CwW-1:0]       cw_raw;
  logic [CwW-1:0]       cw_calc;
  logic [StepW-1:0]     cw_ext;
  logic [StepW-1:0]     step_mx;
  logic [StepW-1:0]     last_calc;
  logic [31:0]          kw_pack [KwCount];

  assign key_flat = {key_reg_q[3], key_reg_q[2], key_reg_q[1], key_reg_q[0]};

  always_comb begin
    len_sat   = (key_len_q > KEY_LEN_W'(MAX_KEY_BYTES)) ? KEY_LEN_W'(MAX_KEY_BYTES)
                                                        : key_len_q;
    len_p3    = {1'b0, len_sat} + (KEY_LEN_W + 1)'(3);
    cw_raw    = CwW'(len_p3 >> 2);
    cw_calc   = (cw_raw == '0) ? CwW'(1) : cw_raw;
    cw_ext    = StepW'(cw_calc);
    step_mx   = (cw_ext > StepW'(RkCount)) ? cw_ext : StepW'(RkCount);
    last_calc = StepW'(step_mx * 3 - 1);
    for (int w = 0; w < KwCount; w++) begin
      for (int k = 0; k < 4; k++) begin
        kw_pack[w][8*k +: 8] = (KEY_LEN_W'(4 * w + k) < len_sat)
                             ? key_flat[8*(4*w+k) +: 8] : 8'h00;
      end
    end
  end

  // key schedule state
  logic [31:0]      ka_q, kb_q, ks_q;
  logic [RkAw-1:0]  ki_q;
  logic [KwAw-1:0]  kj_q;
  logic [StepW-1:0] kn_q, last_q;
  logic [CwW-1:0]   cw_q;
  logic             first_q;
  logic [31:0]      kw_q [KwCount];

  // round-key memory
  logic [31:0]     rk_mem [RkCount];
  logic [31:0]     rd0_q, rd1_q;
  logic [RkAw-1:0] rd_addr0, rd_addr1;

  logic [31:0] key_a_val, kab, key_b_val;

  always_comb begin
    key_a_val = rotl32((first_q ? ks_q : rd0_q) + ka_q + kb_q, 5'd3);
    kab       = ka_q + kb_q;
    key_b_val = rotl32(kw_q[kj_q] + kab, kab[4:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load) begin
      ka_q    <= '0;
      kb_q    <= '0;
      ks_q    <= MAGIC_P;
      ki_q    <= '0;
      kj_q    <= '0;
      kn_q    <= '0;
      first_q <= 1'b1;
      cw_q    <= cw_calc;
      last_q  <= last_calc;
      for (int w = 0; w < KwCount; w++) begin
        kw_q[w] <= kw_pack[w];
      end
    end else if (cmd_i.key_a) begin
      ka_q <= key_a_val;
      ks_q <= ks_q + MAGIC_Q;
      if (ki_q == RkAw'(RkCount - 1)) begin
        ki_q    <= '0;
        first_q <= 1'b0;
      end else begin
        ki_q <= ki_q + RkAw'(1);
      end
    end else if (cmd_i.key_b) begin
      kb_q       <= key_b_val;
      kw_q[kj_q] <= key_b_val;
      kn_q       <= kn_q + StepW'(1);
      if (CwW'(kj_q) == cw_q - CwW'(1)) begin
        kj_q <= '0;
      end else begin
        kj_q <= kj_q + KwAw'(1);
      end
    end
  end

  // block state
  logic [31:0]     wa_q, wb_q, wc_q, wd_q;
  logic [31:0]     wa_d, wb_d, wc_d, wd_d;
  logic [31:0]     pt_q, pu_q, pt_d, pu_d;
  logic [31:0]     x_b, x_d, t_val, u_val, na, nc;
  logic [RndW-1:0] rnd_q;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_PRE: begin
        rd_addr0 = cmd_i.dec ? AddrHiA : AddrLoA;
        rd_addr1 = cmd_i.dec ? AddrHiB : AddrLoB;
      end
      RD_POST: begin
        rd_addr0 = cmd_i.dec ? AddrLoA : AddrHiA;
        rd_addr1 = cmd_i.dec ? AddrLoB : AddrHiB;
      end
      RD_ROUND: begin
        rd_addr0 = RkAw'({rnd_q, 1'b0});
        rd_addr1 = RkAw'({rnd_q, 1'b1});
      end
      RD_KEY: begin
        rd_addr0 = ki_q;
        rd_addr1 = ki_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_a) begin
      rk_mem[ki_q] <= key_a_val;
    end
    rd0_q <= rk_mem[rd_addr0];
    rd1_q <= rk_mem[rd_addr1];
  end

  always_comb begin
    // decrypt rotates the words first, so the mix inputs are the old A and C
    x_b   = cmd_i.dec ? wa_q : wb_q;
    x_d   = cmd_i.dec ? wc_q : wd_q;
    pt_d  = x_b * {x_b[30:0], 1'b1};
    pu_d  = x_d * {x_d[30:0], 1'b1};
    t_val = rotl32(pt_q, 5'd5);
    u_val = rotl32(pu_q, 5'd5);
    na    = rotl32(wa_q ^ t_val, u_val[4:0]) + rd0_q;
    nc    = rotl32(wc_q ^ u_val, t_val[4:0]) + rd1_q;

    wa_d = wa_q;
    wb_d = wb_q;
    wc_d = wc_q;
    wd_d = wd_q;
    priority if (cmd_i.blk_load) begin
      wa_d = in_word_a_i;
      wb_d = in_word_b_i;
      wc_d = in_word_c_i;
      wd_d = in_word_d_i;
    end else if (cmd_i.whiten_in) begin
      if (cmd_i.dec) begin
        wa_d = wa_q - rd0_q;
        wc_d = wc_q - rd1_q;
      end else begin
        wb_d = wb_q + rd0_q;
        wd_d = wd_q + rd1_q;
      end
    end else if (cmd_i.round_mul) begin
      if (cmd_i.dec) begin
        wa_d = wd_q;
        wb_d = wa_q;
        wc_d = wb_q;
        wd_d = wc_q;
      end
    end else if (cmd_i.round_add) begin
      if (cmd_i.dec) begin
        wc_d = rotr32(wc_q - rd1_q, t_val[4:0]) ^ u_val;
        wa_d = rotr32(wa_q - rd0_q, u_val[4:0]) ^ t_val;
      end else begin
        wa_d = wb_q;
        wb_d = nc;
        wc_d = wd_q;
        wd_d = na;
      end
    end else if (cmd_i.whiten_out) begin
      if (cmd_i.dec) begin
        wb_d = wb_q - rd0_q;
        wd_d = wd_q - rd1_q;
      end else begin
        wa_d = wa_q + rd0_q;
        wc_d = wc_q + rd1_q;
      end
    end else begin
      wa_d = wa_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q <= wa_d;
    wb_q <= wb_d;
    wc_q <= wc_d;
    wd_q <= wd_d;
    if (cmd_i.round_mul) begin
      pt_q <= pt_d;
      pu_q <= pu_d;
    end
    if (cmd_i.blk_load) begin
      rnd_q <= cmd_i.dec ? RndW'(ROUNDS) : RndW'(1);
    end else if (cmd_i.round_add) begin
      rnd_q <= cmd_i.dec ? rnd_q - RndW'(1) : rnd_q + RndW'(1);
    end
    if (cmd_i.out_load) begin
      out_word_a_o <= cmd_i.out_nokey ? '0 : wa_q;
      out_word_b_o <= cmd_i.out_nokey ? '0 : wb_q;
      out_word_c_o <= cmd_i.out_nokey ? '0 : wc_q;
      out_word_d_o <= cmd_i.out_nokey ? '0 : wd_q;
      status_o     <= cmd_i.out_nokey;
    end
  end

  assign stat_o.key_last   = (kn_q == last_q);
  assign stat_o.round_last = cmd_i.dec ? (rnd_q == RndW'(1)) : (rnd_q == RndW'(ROUNDS));

endmodule

>>> rtl/rc6_ctrl.sv
`include "rc6_block_cipher_top_defines.svh"

module rc6_ctrl
  import rc6_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ACT_W-1:0] in_action_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rc6_stat_t        stat_i,
  output rc6_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_A,
    ST_KEY_B,
    ST_WHITEN_IN,
    ST_MUL,
    ST_ADD,
    ST_WHITEN_OUT,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q, keys_ready_q, dec_q, nokey_q;
  logic   out_free, act_blk;

  assign out_free   = !out_valid_q || out_ready_i;
  assign act_blk    = (in_action_i == ACT_ENCRYPT) || (in_action_i == ACT_DECRYPT);
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.dec    = dec_q;
    cmd_o.rd_sel = RD_ROUND;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.dec = (in_action_i == ACT_DECRYPT);
        if (in_valid_i) begin
          priority if (in_action_i == ACT_EXPAND) begin
            cmd_o.key_load = 1'b1;
          end else if (act_blk) begin
            cmd_o.blk_load = 1'b1;
            cmd_o.rd_sel   = RD_PRE;
          end else begin
            cmd_o.blk_load = 1'b0;
          end
        end
      end
      ST_KEY_A: cmd_o.key_a = 1'b1;
      ST_KEY_B: begin
        cmd_o.key_b  = 1'b1;
        cmd_o.rd_sel = RD_KEY;
      end
      ST_WHITEN_IN: cmd_o.whiten_in = 1'b1;
      ST_MUL: begin
        cmd_o.round_mul = 1'b1;
        cmd_o.rd_sel    = RD_ROUND;
      end
      ST_ADD: begin
        cmd_o.round_add = 1'b1;
        cmd_o.rd_sel    = RD_POST;
      end
      ST_WHITEN_OUT: cmd_o.whiten_out = 1'b1;
      ST_DONE: begin
        cmd_o.out_load  = out_free;
        cmd_o.out_nokey = nokey_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      keys_ready_q <= 1'b0;
      dec_q        <= 1'b0;
      nokey_q      <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            dec_q   <= (in_action_i == ACT_DECRYPT);
            nokey_q <= !keys_ready_q;
            priority if (in_action_i == ACT_EXPAND) begin
              state_q <= ST_KEY_A;
            end else if (act_blk) begin
              state_q <= keys_ready_q ? ST_WHITEN_IN : ST_DONE;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_KEY_A: state_q <= ST_KEY_B;
        ST_KEY_B: begin
          if (stat_i.key_last) begin
            keys_ready_q <= 1'b1;
            state_q      <= ST_IDLE;
          end else begin
            state_q <= ST_KEY_A;
          end
        end
        ST_WHITEN_IN:  state_q <= ST_MUL;
        ST_MUL:        state_q <= ST_ADD;
        ST_ADD:        state_q <= stat_i.round_last ? ST_WHITEN_OUT : ST_MUL;
        ST_WHITEN_OUT: state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  `RC6_ASSERT_NEXT(a_keys_sticky, keys_ready_q, keys_ready_q)
  `RC6_ASSERT_SAME(a_rounds_need_keys, state_q == ST_WHITEN_IN, keys_ready_q)
  `RC6_ASSERT_NEXT(a_key_phases, state_q == ST_KEY_A, state_q == ST_KEY_B)
  `RC6_ASSERT_NEXT(a_round_phases, state_q == ST_MUL, state_q == ST_ADD)
  `RC6_ASSERT_SAME(a_nokey_result, nokey_q && state_q == ST_DONE, !keys_ready_q)

endmodule

>>> rtl/rc6_block_cipher_top.sv
// Channel     Dir   Word contents
// cfg_i       in    index (register 0..4), data (64 bits)
// blk_in_i    in    action, in_word_a .. in_word_d
// blk_out_o   out   out_word_a .. out_word_d, status
//
// Encrypt/decrypt: input whitening, the rounds and output whitening run in order
//   before the result is registered. In each round the mix multipliers are
//   registered before the rotate-and-add step, as is the round-key memory read.
// Expand key: each schedule step is a key A state and then a key B state, one
//   per half of the A/B update.
// Reset: control state and key words clear, key length 16; the round-key table is
//   not cleared, and blocks before the first expansion return status 1, zeros.
// One word is in flight; a new word is taken while the result still waits, and
//   a finished result holds in the datapath until the output register frees.
module rc6_block_cipher_top
  import rc6_pkg::*;
#(
  parameter int unsigned ROUNDS        = ROUNDS_DEF,
  parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rc6_cfg_if.sink   cfg_i,
  rc6_in_if.sink    blk_in_i,
  rc6_out_if.source blk_out_o
);

  rc6_cmd_t  cmd;
  rc6_stat_t stat;
  logic      in_ready;

  // config writes must come only while idle; not enforced, ready is held high
  assign cfg_i.ready    = 1'b1;
  assign blk_in_i.ready = in_ready;

  rc6_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (blk_in_i.valid),
    .in_action_i (blk_in_i.action),
    .in_ready_o  (in_ready),
    .out_valid_o (blk_out_o.valid),
    .out_ready_i (blk_out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: config registers, key schedule, round-key memory, round logic
  rc6_dp #(
    .ROUNDS        (ROUNDS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .in_word_a_i  (blk_in_i.in_word_a),
    .in_word_b_i  (blk_in_i.in_word_b),
    .in_word_c_i  (blk_in_i.in_word_c),
    .in_word_d_i  (blk_in_i.in_word_d),
    .out_word_a_o (blk_out_o.out_word_a),
    .out_word_b_o (blk_out_o.out_word_b),
    .out_word_c_o (blk_out_o.out_word_c),
    .out_word_d_o (blk_out_o.out_word_d),
    .status_o     (blk_out_o.status)
  );

endmodule
